// ===== src/pag_pkg.sv =====
// ----------------------------------------------------------------------------
// Plate allowlist gate package
// Shared sizes, default parameters, codes and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pag_pkg;

  // Default geometry of the allowlist and the car park.
  localparam int DEF_BUCKETS     = 64;
  localparam int DEF_WAYS        = 4;
  localparam int DEF_LEVEL_COUNT = 5;
  localparam int DEF_PER_LEVEL   = 20;

  // Item field widths.
  localparam int PLATE_W  = 48;
  localparam int BYTE_W   = 8;
  localparam int PLATE_BYTES = PLATE_W / BYTE_W;
  localparam int CAP_W    = 7;
  localparam int OUT_W    = 3;
  localparam int LVL_W    = 3;
  localparam int RES_DATA_W = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd100;

  // Six rounds of h*33+byte from 5381 stay below 2^43, so the hash never wraps.
  localparam int HASH_W    = 43;
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = (HASH_W + MOD_BITS - 1) / MOD_BITS;
  localparam int HASH_PAD  = MOD_STEPS * MOD_BITS;
  localparam logic [HASH_PAD-1:0] HASH_SEED = 44'd5381;

  // Operation carried in tuser.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // Result codes.
  typedef enum logic [OUT_W-1:0] {
    OC_INSERTED    = 3'd0,
    OC_BUCKET_FULL = 3'd1,
    OC_ADMITTED    = 3'd2,
    OC_NOT_LISTED  = 3'd3,
    OC_AT_CAPACITY = 3'd4,
    OC_NO_LEVEL    = 3'd5
  } outcome_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic hash_step;
    logic mod_step;
    logic rd_en;
    logic commit;
  } pag_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic hash_last;
    logic mod_last;
    logic out_free;
  } pag_sts_t;

endpackage

// ===== src/plate_allowlist_entry_gate_core.sv =====
// ----------------------------------------------------------------------------
// Plate allowlist entry gate
// Hash-set allowlist of six-character plates with capacity-limited admission
// and first-fit level assignment.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tuser: opcode; tdata: plate
//  m_axis    out        tdata: outcome, level
//  cfg       in         total capacity, write only
//
// After reset a clearing pass empties the bucket table; s_axis_tready stays
// low meanwhile. One item is worked at a time: six hash rounds, the bucket
// reduction (a bit select for a power-of-two BUCKETS, else remainder steps
// over four hash bits each), one table read and one commit.
// A result waiting in the output register does not block the next input.
// ----------------------------------------------------------------------------
module plate_allowlist_entry_gate_core
  import pag_pkg::*;
#(
  parameter int BUCKETS     = DEF_BUCKETS,
  parameter int WAYS        = DEF_WAYS,
  parameter int LEVEL_COUNT = DEF_LEVEL_COUNT,
  parameter int PER_LEVEL   = DEF_PER_LEVEL
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PLATE_W-1:0]    s_axis_tdata,   // [47:0] plate
  input  logic [0:0]            s_axis_tuser,   // [0] opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [RES_DATA_W-1:0] m_axis_tdata,   // [2:0] outcome, [5:3] level
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_wdata_i
);

  pag_cmd_t cmd;
  pag_sts_t sts;

  // Sequencer.
  pag_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Hash, table and admission datapath.
  pag_dp #(
    .BUCKETS    (BUCKETS),
    .WAYS       (WAYS),
    .LEVEL_COUNT(LEVEL_COUNT),
    .PER_LEVEL  (PER_LEVEL)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_opcode_i(s_axis_tuser[0]),
    .in_plate_i (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ===== src/pag_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered on a read enable.
// ----------------------------------------------------------------------------
module pag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pag_ctrl.sv =====
// ----------------------------------------------------------------------------
// Plate allowlist gate controller
// Sequences the clearing pass, the hash, the bucket reduction, the bucket
// read and the commit of one item at a time.
// ----------------------------------------------------------------------------
module pag_ctrl
  import pag_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pag_sts_t sts_i,
  output pag_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_HASH  = 6'b000100,
    ST_MOD   = 6'b001000,
    ST_READ  = 6'b010000,
    ST_EVAL  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EVAL;
      end
      ST_EVAL: begin
        // Hold until the output register can take the result.
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/pag_dp.sv =====
// ----------------------------------------------------------------------------
// Plate allowlist gate datapath
// Hash unit, bucket reduction, bucket table, way compare, admission counters
// and the output register.
// ----------------------------------------------------------------------------
module pag_dp
  import pag_pkg::*;
#(
  parameter int BUCKETS     = DEF_BUCKETS,
  parameter int WAYS        = DEF_WAYS,
  parameter int LEVEL_COUNT = DEF_LEVEL_COUNT,
  parameter int PER_LEVEL   = DEF_PER_LEVEL
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pag_cmd_t              cmd_i,
  output pag_sts_t              sts_o,
  input  logic                  in_opcode_i,
  input  logic [PLATE_W-1:0]    in_plate_i,
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_wdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [RES_DATA_W-1:0] out_data_o
);

  localparam int  IDX_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam bit  IS_POW2 = (BUCKETS > 1) && ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam int  MOD_CYC = IS_POW2 ? 1 : MOD_STEPS;
  localparam int  MCNT_W  = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int  BCNT_W  = $clog2(PLATE_BYTES);
  localparam int  ENTRY_W = PLATE_W + 1;
  localparam int  ROW_W   = WAYS * ENTRY_W;
  localparam int  FILL_W  = $clog2(PER_LEVEL + 1);
  localparam logic [IDX_W:0]      BKT_T    = (IDX_W + 1)'(BUCKETS);
  localparam logic [FILL_W-1:0]   FILL_MAX = FILL_W'(PER_LEVEL);

  // Item and hash registers.
  logic                  opcode_q;
  logic [PLATE_W-1:0]    plate_q, plate_sh_q;
  logic [HASH_PAD-1:0]   hash_q, hash_d;
  logic [IDX_W-1:0]      bkt_q, bkt_d;
  logic [BCNT_W-1:0]     byte_cnt_q;
  logic [MCNT_W-1:0]     mod_cnt_q;
  logic [IDX_W-1:0]      clr_q;

  // Admission state and configuration.
  logic [CAP_W-1:0]      cap_q;
  logic [CAP_W-1:0]      count_q;
  logic [FILL_W-1:0]     fill_q [LEVEL_COUNT];

  // Output register.
  logic                  out_valid_q;
  logic [RES_DATA_W-1:0] out_data_q;

  // Bucket table access.
  logic [WAYS-1:0][ENTRY_W-1:0] row_rd, row_wr;
  logic [ROW_W-1:0]             ram_rdata, ram_wdata;
  logic [IDX_W-1:0]             ram_waddr;
  logic                         ram_we;

  // Evaluation results.
  logic                   hit, free_found, lvl_found, row_upd, count_inc;
  logic [LEVEL_COUNT-1:0] fill_inc;
  logic [LVL_W-1:0]       lvl_num, res_level;
  outcome_e               res_outcome;

  // Status back to the controller.
  assign sts_o.clear_last = (clr_q == IDX_W'(BUCKETS - 1));
  assign sts_o.hash_last  = (byte_cnt_q == BCNT_W'(PLATE_BYTES - 1));
  assign sts_o.mod_last   = (mod_cnt_q == MCNT_W'(MOD_CYC - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Hash round and bucket reduction. The reduction takes MOD_BITS hash bits
  // per cycle, most significant first, keeping the running remainder.
  always_comb begin
    logic [IDX_W-1:0] r;
    logic [IDX_W:0]   t;
    hash_d = hash_q;
    bkt_d  = bkt_q;
    r      = bkt_q;
    t      = '0;
    if (cmd_i.hash_step) begin
      hash_d = (hash_q << 5) + hash_q + HASH_PAD'(plate_sh_q[PLATE_W-1 -: BYTE_W]);
    end else if (cmd_i.mod_step) begin
      if (IS_POW2) begin
        bkt_d = hash_q[IDX_W-1:0];
      end else begin
        for (int j = 0; j < MOD_BITS; j++) begin
          t = {r, hash_q[HASH_PAD-1-j]};
          if (t >= BKT_T) begin
            t = t - BKT_T;
          end
          r = t[IDX_W-1:0];
        end
        bkt_d  = r;
        hash_d = hash_q << MOD_BITS;
      end
    end
  end

  // Item, hash and sequencing counters.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      opcode_q   <= in_opcode_i;
      plate_q    <= in_plate_i;
      plate_sh_q <= in_plate_i;
      hash_q     <= HASH_SEED;
      bkt_q      <= '0;
    end else begin
      hash_q <= hash_d;
      bkt_q  <= bkt_d;
      if (cmd_i.hash_step) begin
        plate_sh_q <= plate_sh_q << BYTE_W;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      mod_cnt_q  <= '0;
      clr_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        byte_cnt_q <= '0;
        mod_cnt_q  <= '0;
      end else begin
        if (cmd_i.hash_step) begin
          byte_cnt_q <= byte_cnt_q + 1'b1;
        end
        if (cmd_i.mod_step) begin
          mod_cnt_q <= mod_cnt_q + 1'b1;
        end
      end
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // Bucket table: one row per bucket, each way a valid bit over a plate.
  assign row_rd    = ram_rdata;
  assign ram_we    = cmd_i.clear_step || (cmd_i.commit && row_upd);
  assign ram_waddr = cmd_i.clear_step ? clr_q : bkt_q;
  assign ram_wdata = cmd_i.clear_step ? '0 : row_wr;

  pag_ram #(
    .WIDTH(ROW_W),
    .DEPTH(BUCKETS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(bkt_q),
    .rdata_o(ram_rdata)
  );

  // Way compare, first free way, and first level with room.
  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    row_wr     = row_rd;
    for (int w = 0; w < WAYS; w++) begin
      if (row_rd[w][PLATE_W] && (row_rd[w][PLATE_W-1:0] == plate_q)) begin
        hit = 1'b1;
      end
      if (!row_rd[w][PLATE_W] && !free_found) begin
        free_found = 1'b1;
        row_wr[w]  = {1'b1, plate_q};
      end
    end
    lvl_found = 1'b0;
    lvl_num   = '0;
    fill_inc  = '0;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (!lvl_found && (fill_q[i] < FILL_MAX)) begin
        lvl_found   = 1'b1;
        lvl_num     = LVL_W'(i + 1);
        fill_inc[i] = 1'b1;
      end
    end
  end

  // Outcome of the item.
  always_comb begin
    row_upd     = 1'b0;
    count_inc   = 1'b0;
    res_level   = '0;
    res_outcome = OC_NOT_LISTED;
    if (opcode_q == OP_INSERT) begin
      row_upd     = free_found;
      res_outcome = free_found ? OC_INSERTED : OC_BUCKET_FULL;
    end else if (!hit) begin
      res_outcome = OC_NOT_LISTED;
    end else if (count_q >= cap_q) begin
      res_outcome = OC_AT_CAPACITY;
    end else begin
      count_inc = 1'b1;
      if (lvl_found) begin
        res_outcome = OC_ADMITTED;
        res_level   = lvl_num;
      end else begin
        res_outcome = OC_NO_LEVEL;
      end
    end
  end

  // Capacity register, admitted count and level fill counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      count_q <= '0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.commit && count_inc) begin
        count_q <= count_q + 1'b1;
        if (res_outcome == OC_ADMITTED) begin
          for (int i = 0; i < LEVEL_COUNT; i++) begin
            if (fill_inc[i]) begin
              fill_q[i] <= fill_q[i] + 1'b1;
            end
          end
        end
      end
    end
  end

  // Output register: loaded on commit, emptied when the result is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {(RES_DATA_W - LVL_W - OUT_W)'(0), res_level, res_outcome};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/pag_checker.sv =====
// ----------------------------------------------------------------------------
// Plate allowlist gate port checker
// Watches the top-level ports for result hold, item spacing and result
// field consistency.
// ----------------------------------------------------------------------------
module pag_checker
  import pag_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [RES_DATA_W-1:0] m_axis_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // The block works one item at a time.
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken in back-to-back cycles");

  // No fresh result can appear in the cycle after an item is taken.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // Outcome is a known code, padding is zero, level only on admission.
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] <= OC_NO_LEVEL) && (m_axis_tdata[7:6] == 2'b00)
      && ((m_axis_tdata[2:0] == OC_ADMITTED) || (m_axis_tdata[5:3] == 3'd0)))
    else $error("inconsistent result fields");

endmodule

bind plate_allowlist_entry_gate_core pag_checker u_pag_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Plate allowlist entry gate testbench
// Drives insert and lookup items into the gate and predicts each outcome and
// level from a local copy of the bucket table, admitted count and level fill.
// Every result item is checked field by field, in order, against the oldest
// prediction. Directed cases come first, then random traffic under several
// capacity settings with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  import pag_pkg::*;

  localparam int BUCKETS     = DEF_BUCKETS;
  localparam int WAYS        = DEF_WAYS;
  localparam int LEVEL_COUNT = DEF_LEVEL_COUNT;
  localparam int PER_LEVEL   = DEF_PER_LEVEL;
  localparam int SLOTS       = BUCKETS * WAYS;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    outcome_e          outcome;
    logic [LVL_W-1:0]  level;
  } verdict_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [PLATE_W-1:0]    s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [RES_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [CAP_W-1:0]      cfg_wdata_i;

  // Local copy of the gate state used for prediction.
  logic [PLATE_W-1:0] slot_plate [SLOTS];
  bit                 slot_used  [SLOTS];
  int unsigned        cars_in;
  int unsigned        level_fill [LEVEL_COUNT];
  logic [CAP_W-1:0]   cap_limit;

  verdict_t           verdict_q [$];
  logic [PLATE_W-1:0] listed_plates [$];
  int unsigned        err_cnt;
  int unsigned        cycle_cnt;
  int unsigned        sink_wait;
  int unsigned        sink_hold_cycles;
  bit                 idle_en;

  plate_allowlist_entry_gate_core #(
    .BUCKETS    (BUCKETS),
    .WAYS       (WAYS),
    .LEVEL_COUNT(LEVEL_COUNT),
    .PER_LEVEL  (PER_LEVEL)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Clock with a period of 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // djb2 over the six plate bytes, first character first, then the bucket.
  function automatic int unsigned plate_bucket(logic [PLATE_W-1:0] plate);
    logic [63:0] h;
    h = 64'd5381;
    for (int k = PLATE_BYTES - 1; k >= 0; k--) begin
      h = h * 64'd33 + {56'd0, plate[k*BYTE_W +: BYTE_W]};
    end
    return int'(h % BUCKETS);
  endfunction

  // Works out the outcome of one item and updates the local gate state.
  function automatic verdict_t predict_gate(op_e op, logic [PLATE_W-1:0] plate);
    verdict_t    v;
    int unsigned base;
    bit          hit;
    v.level = '0;
    hit     = 1'b0;
    base    = plate_bucket(plate) * WAYS;
    if (op == OP_INSERT) begin
      v.outcome = OC_BUCKET_FULL;
      for (int w = 0; w < WAYS; w++) begin
        if (!hit && !slot_used[base+w]) begin
          slot_used[base+w]  = 1'b1;
          slot_plate[base+w] = plate;
          v.outcome          = OC_INSERTED;
          hit                = 1'b1;
        end
      end
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (slot_used[base+w] && slot_plate[base+w] == plate) hit = 1'b1;
      end
      if (!hit) begin
        v.outcome = OC_NOT_LISTED;
      end else if (cars_in >= cap_limit) begin
        v.outcome = OC_AT_CAPACITY;
      end else begin
        // The car is counted even when every level is full.
        cars_in   = cars_in + 1;
        v.outcome = OC_NO_LEVEL;
        for (int i = 0; i < LEVEL_COUNT; i++) begin
          if (v.outcome == OC_NO_LEVEL && level_fill[i] < PER_LEVEL) begin
            level_fill[i]++;
            v.level   = LVL_W'(i + 1);
            v.outcome = OC_ADMITTED;
          end
        end
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // Compares one result item with the oldest prediction.
  task automatic check_result(input logic [RES_DATA_W-1:0] data);
    verdict_t v;
    if (verdict_q.size() == 0) begin
      report_mismatch($sformatf("result item 0x%02h with nothing expected", data));
    end else begin
      v = verdict_q.pop_front();
      if (data[OUT_W-1:0] !== v.outcome)
        report_mismatch($sformatf("outcome %0d, expected %0d", data[OUT_W-1:0], v.outcome));
      if (data[OUT_W +: LVL_W] !== v.level)
        report_mismatch($sformatf("level %0d, expected %0d", data[OUT_W +: LVL_W], v.level));
      if (data[RES_DATA_W-1:OUT_W+LVL_W] !== '0)
        report_mismatch($sformatf("padding bits 0x%0h", data[RES_DATA_W-1:OUT_W+LVL_W]));
    end
  endtask

  // Result sink: checks every accepted item and stalls at random or on request.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata);
      sink_wait = idle_en ? $urandom_range(0, 10) : 0;
    end
    if (sink_hold_cycles > 0) begin
      sink_hold_cycles--;
      m_axis_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Sends one item after a random gap and predicts its result on acceptance.
  task automatic send_item(input op_e op, input logic [PLATE_W-1:0] plate);
    int unsigned gap;
    verdict_t    v;
    gap = idle_en ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= plate;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    v = predict_gate(op, plate);
    verdict_q.push_back(v);
    if (op == OP_INSERT && v.outcome == OC_INSERTED) listed_plates.push_back(plate);
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic settle_gate();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    settle_gate();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_limit   = value;
  endtask

  function automatic logic [PLATE_W-1:0] ascii_plate();
    logic [PLATE_W-1:0] p;
    for (int k = 0; k < PLATE_BYTES; k++) begin
      if ($urandom_range(0, 1)) p[k*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range("A", "Z"));
      else p[k*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range("0", "9"));
    end
    return p;
  endfunction

  function automatic logic [PLATE_W-1:0] random_plate();
    logic [PLATE_W-1:0] p;
    case ($urandom_range(0, 9))
      0, 1, 2: p = PLATE_W'({$urandom(), $urandom()});
      3, 4: begin
        // Bytes with the top bit set.
        for (int k = 0; k < PLATE_BYTES; k++) begin
          p[k*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(128, 255));
        end
      end
      5: p = $urandom_range(0, 1) ? '0 : '1;
      default: p = ascii_plate();
    endcase
    return p;
  endfunction

  // Draws plates until one hashes into the given bucket.
  function automatic logic [PLATE_W-1:0] plate_for_bucket(int unsigned bucket);
    logic [PLATE_W-1:0] p;
    do p = ascii_plate(); while (plate_bucket(p) != bucket);
    return p;
  endfunction

  task automatic test_empty_table();
    send_item(OP_LOOKUP, '0);
    send_item(OP_LOOKUP, '1);
    send_item(OP_LOOKUP, "XFF000");
  endtask

  task automatic test_insert_admit();
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, '1);
    send_item(OP_INSERT, "XFF000");
    send_item(OP_INSERT, 48'h80FF_C0A5_9E81);
    // A duplicate takes a second way of the same bucket.
    send_item(OP_INSERT, "XFF000");
    send_item(OP_LOOKUP, '0);
    send_item(OP_LOOKUP, '1);
    send_item(OP_LOOKUP, "XFF000");
    send_item(OP_LOOKUP, 48'h80FF_C0A5_9E81);
  endtask

  task automatic test_bucket_full();
    int unsigned        bucket;
    logic [PLATE_W-1:0] first_plate;
    logic [PLATE_W-1:0] p;
    bucket      = $urandom_range(0, BUCKETS - 1);
    first_plate = plate_for_bucket(bucket);
    send_item(OP_INSERT, first_plate);
    p = first_plate;
    repeat (WAYS) begin
      p = plate_for_bucket(bucket);
      send_item(OP_INSERT, p);
    end
    send_item(OP_LOOKUP, p);
    send_item(OP_LOOKUP, first_plate);
  endtask

  task automatic test_capacity_zero();
    set_capacity('0);
    send_item(OP_LOOKUP, "XFF000");
    send_item(OP_LOOKUP, plate_for_bucket(0));
  endtask

  // Mostly inserts and lookups of listed plates, with some noise.
  task automatic run_gate_traffic(input int unsigned n_items);
    int unsigned pick;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_item(OP_INSERT, random_plate());
      end else if (pick < 30) begin
        send_item(OP_INSERT, plate_for_bucket($urandom_range(0, BUCKETS - 1)));
      end else if (pick < 35 && listed_plates.size() > 0) begin
        send_item(OP_INSERT, listed_plates[$urandom_range(0, listed_plates.size() - 1)]);
      end else if (pick < 88 && listed_plates.size() > 0) begin
        send_item(OP_LOOKUP, listed_plates[$urandom_range(0, listed_plates.size() - 1)]);
      end else begin
        send_item(OP_LOOKUP, random_plate());
      end
    end
  endtask

  // The sink holds off while items keep coming, then the sender drains fully.
  task automatic test_backpressure();
    idle_en          = 1'b0;
    sink_hold_cycles = 250;
    run_gate_traffic(12);
    settle_gate();
    run_gate_traffic(12);
    idle_en = 1'b1;
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    run_gate_traffic(150);
    idle_en = 1'b1;
  endtask

  // Test sequence.
  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = '0;
    m_axis_tready    = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    err_cnt          = 0;
    cycle_cnt        = 0;
    sink_wait        = 0;
    sink_hold_cycles = 0;
    idle_en          = 1'b1;
    cars_in          = 0;
    cap_limit        = CAP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i]  = 1'b0;
      slot_plate[i] = '0;
    end
    for (int i = 0; i < LEVEL_COUNT; i++) level_fill[i] = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_insert_admit();
    test_bucket_full();
    test_capacity_zero();

    set_capacity(CAP_W'($urandom_range(1, 30)));
    run_gate_traffic(250);
    test_backpressure();
    set_capacity(7'd60);
    run_gate_traffic(250);
    test_back_to_back();
    set_capacity(7'd100);
    run_gate_traffic(300);
    // Above the level space, so late arrivals get no level.
    set_capacity(7'd127);
    run_gate_traffic(400);
    set_capacity(CAP_W'($urandom_range(0, 127)));
    run_gate_traffic(200);

    settle_gate();
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
